>>> hdl/tpod_pkg.sv
// ----------------------------------------------------------------------------
// tpod_pkg
// Shared types, constants and the 4x interpolator coefficient table for the
// true peak detector.
// ----------------------------------------------------------------------------
package tpod_pkg;

    // Sizes
    localparam int MAX_CHANNELS   = 8;
    localparam int SAMPLE_BITS    = 24;
    localparam int NUM_TAPS       = 12;
    localparam int NUM_PHASES     = 4;
    localparam int COEF_BITS      = 17;
    localparam int COEF_FRAC_BITS = 16;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS       = PROD_BITS + 3;
    localparam int PEAK_BITS      = 25;
    localparam int CH_BITS        = 3;
    localparam int TAP_BITS       = $clog2(NUM_TAPS);
    localparam int PH_BITS        = $clog2(NUM_PHASES);
    localparam int MEM_DEPTH      = MAX_CHANNELS * NUM_TAPS;
    localparam int ADDR_BITS      = $clog2(MEM_DEPTH);

    localparam logic [TAP_BITS-1:0] LAST_TAP   = TAP_BITS'(NUM_TAPS - 1);
    localparam logic [PH_BITS-1:0]  LAST_PHASE = PH_BITS'(NUM_PHASES - 1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Control travelling alongside each multiply-accumulate
    typedef struct packed {
        logic valid;
        logic first;   // first tap of a phase: restart the sum
        logic last;    // last tap of a phase: magnitude follows
        logic fin;     // last tap of the last phase of the item
    } mac_ctrl_t;

    // Phase magnitude coming back from the MAC unit
    typedef struct packed {
        logic                 valid;
        logic                 fin;
        logic [PEAK_BITS-1:0] mag;
    } mac_res_t;

    // 4x polyphase interpolator, Q.16
    localparam logic signed [COEF_BITS-1:0] COEF_TABLE [NUM_PHASES][NUM_TAPS] = '{
        '{  17'sd112,    17'sd720,   -17'sd1288,  17'sd2176, -17'sd3896,  17'sd9000,
            17'sd63712, -17'sd6704,   17'sd3120, -17'sd1744,  17'sd976,  -17'sd544 },
        '{ -17'sd1912,   17'sd1920,  -17'sd3392,  17'sd5840, -17'sd10912, 17'sd30480,
            17'sd51104, -17'sd13128,  17'sd6656, -17'sd3816,  17'sd2168, -17'sd1240 },
        '{ -17'sd1240,   17'sd2168,  -17'sd3816,  17'sd6656, -17'sd13128, 17'sd51104,
            17'sd30480, -17'sd10912,  17'sd5840, -17'sd3392,  17'sd1920, -17'sd1912 },
        '{ -17'sd544,    17'sd976,   -17'sd1744,  17'sd3120, -17'sd6704,  17'sd63712,
            17'sd9000,  -17'sd3896,   17'sd2176, -17'sd1288,  17'sd720,   17'sd112 }
    };

endpackage

>>> hdl/tpod_mac.sv
// ----------------------------------------------------------------------------
// tpod_mac
// Shared multiply-accumulate unit: one tap product per cycle, exact phase sum,
// then the truncated magnitude of each finished phase.
// ----------------------------------------------------------------------------
module tpod_mac
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tpod_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [tpod_pkg::SAMPLE_BITS-1:0] tap_data,
    input  logic signed [tpod_pkg::COEF_BITS-1:0]   coef,
    output tpod_pkg::mac_res_t                    res
);
    import tpod_pkg::*;

    mac_ctrl_t                    prod_ctrl_reg;
    mac_ctrl_t                    acc_ctrl_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [ACC_BITS-1:0]   acc_reg;
    logic signed [ACC_BITS-1:0]   acc_base;
    logic        [ACC_BITS-1:0]   acc_abs;
    mac_res_t                     res_reg;

    // Control pipeline and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctrl_reg <= '0;
            acc_ctrl_reg  <= '0;
            res_reg       <= '0;
        end
        else
        begin
            prod_ctrl_reg <= ctrl;
            acc_ctrl_reg  <= prod_ctrl_reg;
            res_reg.valid <= acc_ctrl_reg.valid && acc_ctrl_reg.last;
            res_reg.fin   <= acc_ctrl_reg.valid && acc_ctrl_reg.fin;
            // magnitude, truncated to sample units
            res_reg.mag   <= acc_abs[COEF_FRAC_BITS +: PEAK_BITS];
        end
    end

    // Product, then running sum
    assign acc_base = prod_ctrl_reg.first ? '0 : acc_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_BITS'(tap_data * coef);
        if (prod_ctrl_reg.valid)
        begin
            acc_reg <= acc_base + ACC_BITS'(prod_reg);
        end
    end

    // Magnitude of the finished sum
    assign acc_abs = acc_reg[ACC_BITS-1] ? ACC_BITS'(-acc_reg) : ACC_BITS'(acc_reg);

    assign res = res_reg;

endmodule

>>> hdl/true_peak_oversampling_detector_unit.sv
// ----------------------------------------------------------------------------
// true_peak_oversampling_detector_unit
// 4x polyphase true peak meter: per-channel delay lines, one shared MAC,
// running peak over all phases and channels.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------
//  input   | in_valid / in_ready  | channel [2:0], sample [23:0]
//  output  | out_valid / out_ready| peak [24:0]
//
//  Each item runs 48 MAC steps through the single shared multiplier
//  (4 phases x 12 taps, one delay-line memory read each), then drains
//  the read/multiply/sum/magnitude pipeline and posts the result.
//  Reset clears the tap valid bits at once, so there is no clearing pass.
//  A stalled output holds back only the end of the next item.
// ----------------------------------------------------------------------------
module true_peak_oversampling_detector_unit
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [tpod_pkg::CH_BITS-1:0]            channel,
    input  logic signed [tpod_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [tpod_pkg::PEAK_BITS-1:0]          peak
);
    import tpod_pkg::*;

    state_t                        state_reg;
    state_t                        state_next;

    // Delay-line memory, circular per channel; newest tap sits at the head
    logic signed [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]          tap_vld_reg;
    logic [TAP_BITS-1:0]           head_reg [MAX_CHANNELS];

    logic [CH_BITS-1:0]            ch_reg;
    logic [TAP_BITS-1:0]           head_item_reg;
    logic [TAP_BITS-1:0]           pos_reg;
    logic [TAP_BITS-1:0]           k_reg;
    logic [PH_BITS-1:0]            ph_reg;

    logic [TAP_BITS-1:0]           new_head;
    logic [ADDR_BITS-1:0]          wr_addr;
    logic [ADDR_BITS-1:0]          rd_addr;
    logic                          in_fire;
    logic                          issue;
    logic                          out_load;
    mac_ctrl_t                     issue_ctrl;

    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          rd_vld_reg;
    mac_ctrl_t                     rd_ctrl_reg;
    logic [TAP_BITS-1:0]           rd_k_reg;
    logic [PH_BITS-1:0]            rd_ph_reg;
    logic signed [SAMPLE_BITS-1:0] tap_data;
    logic signed [COEF_BITS-1:0]   coef;
    mac_res_t                      mac_res;

    logic [PEAK_BITS-1:0]          peak_reg;
    logic [PEAK_BITS-1:0]          peak_out_reg;
    logic                          out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (k_reg == LAST_TAP && ph_reg == LAST_PHASE)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (mac_res.valid && mac_res.fin)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_RUN:   issue    = 1'b1;
            ST_DRAIN: ;
            ST_OUT:   out_load = !out_valid_reg || out_ready;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_fire  = in_valid && in_ready;
    // Head moves back one place so that tap k sits at head + k
    assign new_head = (head_reg[channel] == '0) ? LAST_TAP
                                                : head_reg[channel] - TAP_BITS'(1);
    assign wr_addr  = ADDR_BITS'(channel) * ADDR_BITS'(NUM_TAPS) + ADDR_BITS'(new_head);
    assign rd_addr  = ADDR_BITS'(ch_reg) * ADDR_BITS'(NUM_TAPS) + ADDR_BITS'(pos_reg);

    // Head pointers and tap valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_vld_reg <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
                head_reg[i] <= '0;
        end
        else if (in_fire)
        begin
            tap_vld_reg[wr_addr] <= 1'b1;
            head_reg[channel]    <= new_head;
        end
    end

    // Delay-line memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (in_fire)
            mem[wr_addr] <= sample;
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= tap_vld_reg[rd_addr];
    end

    // Tap and phase counters
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg        <= channel;
            head_item_reg <= new_head;
            pos_reg       <= new_head;
            k_reg         <= '0;
            ph_reg        <= '0;
        end
        else if (issue)
        begin
            if (k_reg == LAST_TAP)
            begin
                k_reg   <= '0;
                pos_reg <= head_item_reg;
                ph_reg  <= ph_reg + PH_BITS'(1);
            end
            else
            begin
                k_reg   <= k_reg + TAP_BITS'(1);
                pos_reg <= (pos_reg == LAST_TAP) ? '0 : pos_reg + TAP_BITS'(1);
            end
        end
    end

    // Control issued with each read
    always_comb
    begin
        issue_ctrl.valid = issue;
        issue_ctrl.first = k_reg == '0;
        issue_ctrl.last  = k_reg == LAST_TAP;
        issue_ctrl.fin   = k_reg == LAST_TAP && ph_reg == LAST_PHASE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_ctrl_reg <= '0;
        else
            rd_ctrl_reg <= issue_ctrl;
    end

    always_ff @(posedge clk)
    begin
        rd_k_reg  <= k_reg;
        rd_ph_reg <= ph_reg;
    end

    // Unwritten taps read as zero
    assign tap_data = rd_vld_reg ? rd_data_reg : '0;
    assign coef     = COEF_TABLE[rd_ph_reg][rd_k_reg];

    tpod_mac u_mac
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (rd_ctrl_reg),
        .tap_data (tap_data),
        .coef     (coef),
        .res      (mac_res)
    );

    // Running peak and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mac_res.valid && mac_res.mag > peak_reg)
                peak_reg <= mac_res.mag;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            peak_out_reg <= peak_reg;
    end

    assign out_valid = out_valid_reg;
    assign peak      = peak_out_reg;

endmodule

>>> sim/true_peak_oversampling_detector_unit_test.sv
// ----------------------------------------------------------------------------
// true_peak_oversampling_detector_unit_test
// Self-checking bench for the 4x polyphase true peak meter. An in-bench
// predictor keeps its own per-channel sample history and running peak and
// works out the peak due after each accepted item. Every result is checked
// against the oldest pending prediction. Both handshakes idle at random.
// The peak never falls and only reset clears it, so the stimulus starts
// small and grows. Full-scale items therefore come last.
// ----------------------------------------------------------------------------
module true_peak_oversampling_detector_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tpod_pkg::*;

    // Bench constants
    localparam int CYCLE_LIMIT = 1500000;
    localparam int LATENCY     = 60;
    localparam int LONG_HOLD   = 400;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;

    // 4x interpolator taps in units of 2^-16, newest sample at tap 0
    localparam int INTERP_Q16 [NUM_PHASES][NUM_TAPS] = '{
        '{   112,    720,  -1288,   2176,  -3896,   9000,
           63712,  -6704,   3120,  -1744,    976,   -544 },
        '{ -1912,   1920,  -3392,   5840, -10912,  30480,
           51104, -13128,   6656,  -3816,   2168,  -1240 },
        '{ -1240,   2168,  -3816,   6656, -13128,  51104,
           30480, -10912,   5840,  -3392,   1920,  -1912 },
        '{  -544,    976,  -1744,   3120,  -6704,  63712,
            9000,  -3896,   2176,  -1288,    720,    112 }
    };

    // DUT ports
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic [CH_BITS-1:0]            channel   = '0;
    logic signed [SAMPLE_BITS-1:0] sample    = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [PEAK_BITS-1:0]          peak;

    // Predictor state
    logic signed [SAMPLE_BITS-1:0] tap_hist [MAX_CHANNELS][NUM_TAPS];
    logic [PEAK_BITS-1:0]          running_peak_model;
    logic [PEAK_BITS-1:0]          peak_expected [$];
    logic [PEAK_BITS-1:0]          peak_want;

    // Bench control
    int check_errors      = 0;
    int cycle_count       = 0;
    bit tx_idle_on        = 1'b1;
    bit rx_idle_on        = 1'b1;
    int long_holds_asked  = 0;
    int long_holds_served = 0;
    int rx_stall_left     = 0;

    true_peak_oversampling_detector_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .channel   (channel),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .peak      (peak)
    );

    always #10 clk = ~clk;

    // Shift the sample into its channel, run all four phases, update the peak
    function automatic logic [PEAK_BITS-1:0] predict_peak
    (
        input logic [CH_BITS-1:0]            ch,
        input logic signed [SAMPLE_BITS-1:0] s
    );
        longint acc;
        longint mag;
        if (ch < MAX_CHANNELS)
        begin
            for (int k = NUM_TAPS - 1; k > 0; k--)
                tap_hist[ch][k] = tap_hist[ch][k-1];
            tap_hist[ch][0] = s;
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                acc = 0;
                for (int k = 0; k < NUM_TAPS; k++)
                    acc += longint'(INTERP_Q16[p][k]) * longint'(tap_hist[ch][k]);
                // magnitude first, then truncate: rounds toward zero
                mag = (acc < 0) ? -acc : acc;
                mag = mag >> COEF_FRAC_BITS;
                if (mag > longint'(running_peak_model))
                    running_peak_model = mag[PEAK_BITS-1:0];
            end
        end
        return running_peak_model;
    endfunction

    // Sender gap: mostly none or short, a few long
    function automatic int tx_gap_len();
        int r;
        if (!tx_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 80)
            return $urandom_range(1, 10);
        if (r < 95)
            return $urandom_range(11, 70);
        return $urandom_range(71, 250);
    endfunction

    // Receiver stall: mostly short, a few long
    function automatic int rx_stall_len();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(20, 120);
    endfunction

    // Offer one item and hold it until accepted, then log its prediction
    task automatic send_sample
    (
        input logic [CH_BITS-1:0]            ch,
        input logic signed [SAMPLE_BITS-1:0] s
    );
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= s;
        do
            @(posedge clk);
        while (!in_ready);
        peak_expected.push_back(predict_peak(ch, s));
    endtask

    task automatic pause_sender();
        int n;
        n = tx_gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (peak_expected.size() != 0)
            @(posedge clk);
    endtask

    // Negative sub-unit outputs must truncate to zero, not to one
    task automatic test_truncation();
        send_sample(3'd2, -24'sd1);
        pause_sender();
        repeat (6)
        begin
            send_sample(3'd2, 24'sd0);
            pause_sender();
        end
    endtask

    // One impulse per channel, growing, so each line must stay apart
    task automatic test_channel_isolation();
        int mag;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            mag = (c + 1) * 4096;
            send_sample(CH_BITS'(c), SAMPLE_BITS'((c % 2 == 0) ? mag : -mag));
            pause_sender();
        end
    endtask

    // Random items whose amplitude envelope grows from 2^exp_lo to 2^exp_hi.
    // A quarter of them negate the channel's last sample (tone near Nyquist).
    // The middle stretch runs with no idling on either side.
    task automatic test_random_ramp(input int n_items, input int exp_lo, input int exp_hi);
        int                            e;
        int                            lim;
        logic [CH_BITS-1:0]            ch;
        logic signed [SAMPLE_BITS-1:0] s;
        for (int i = 0; i < n_items; i++)
        begin
            tx_idle_on = !(i >= n_items / 3 && i < n_items / 2);
            rx_idle_on = tx_idle_on;
            e   = exp_lo + (i * (exp_hi - exp_lo + 1)) / n_items;
            lim = 1 << e;
            ch  = CH_BITS'($urandom_range(0, MAX_CHANNELS - 1));
            if ($urandom_range(0, 3) == 0)
                s = (tap_hist[ch][0] == SAMPLE_MIN) ? SAMPLE_MAX : -tap_hist[ch][0];
            else
                s = SAMPLE_BITS'(int'($urandom_range(0, 2 * lim - 1)) - lim);
            send_sample(ch, s);
            pause_sender();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        long_holds_asked++;
        repeat (12)
        begin
            send_sample(CH_BITS'($urandom_range(0, MAX_CHANNELS - 1)),
                        SAMPLE_BITS'(int'($urandom_range(0, 32767)) - 16384));
            pause_sender();
        end
        tx_idle_on = 1'b1;
    endtask

    // Back-to-back burst, sender waits for the block to drain, then resumes
    task automatic test_idle_restart();
        tx_idle_on = 1'b0;
        repeat (4)
            send_sample(CH_BITS'($urandom_range(0, MAX_CHANNELS - 1)),
                        SAMPLE_BITS'(int'($urandom_range(0, 32767)) - 16384));
        wait_drained();
        repeat (4)
            send_sample(CH_BITS'($urandom_range(0, MAX_CHANNELS - 1)),
                        SAMPLE_BITS'(int'($urandom_range(0, 32767)) - 16384));
        tx_idle_on = 1'b1;
        pause_sender();
    endtask

    // Full-scale samples signed to match phase 1 taps: the largest possible
    // output, which needs the top peak bit
    task automatic test_full_scale();
        for (int k = NUM_TAPS - 1; k >= 0; k--)
        begin
            send_sample(CH_BITS'(MAX_CHANNELS - 1),
                        (INTERP_Q16[1][k] < 0) ? SAMPLE_MIN : SAMPLE_MAX);
            pause_sender();
        end
    endtask

    // Receiver: random stalls, plus the long hold on request
    always @(posedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            out_ready <= 1'b0;
        end
        else if (long_holds_served != long_holds_asked)
        begin
            long_holds_served++;
            rx_stall_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_stall_left = rx_stall_len() - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Result check against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (peak_expected.size() == 0)
            begin
                check_errors++;
                $display("%0t: unexpected result, expected none, actual peak %0d",
                         $time, peak);
            end
            else
            begin
                peak_want = peak_expected.pop_front();
                if (peak !== peak_want)
                begin
                    check_errors++;
                    $display("%0t: peak mismatch, expected %0d, actual %0d",
                             $time, peak_want, peak);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        for (int c = 0; c < MAX_CHANNELS; c++)
            for (int k = 0; k < NUM_TAPS; k++)
                tap_hist[c][k] = '0;
        running_peak_model = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_truncation();
        test_channel_isolation();
        test_random_ramp(300, 3, 13);
        test_output_backpressure();
        test_idle_restart();
        test_random_ramp(300, 14, 23);
        test_full_scale();

        // let the last results through, then allow for stragglers
        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);

        if (check_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
